>>> sv/dmma_pkg.sv
package dmma_pkg;

  localparam int MAX_SIZE     = 16;
  localparam int ELEMENT_BITS = 32;
  localparam int CELLS        = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W       = $clog2(CELLS);
  localparam int IDX_W        = $clog2(MAX_SIZE);
  localparam int ORD_W        = IDX_W + 1;
  localparam int PROD_W       = 2 * ELEMENT_BITS;
  localparam int ACC_W        = PROD_W + 8;
  localparam int FRAC_BITS    = 16;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_LOAD_C  = 2'd2;
  localparam logic [1:0] KIND_COMPUTE = 2'd3;

  typedef struct packed {
    logic             load;
    logic [1:0]       load_kind;
    logic             issue;
    logic             first;
    logic             last;
    logic             store;
    logic             last_col;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
    logic [ORD_W-1:0] order;
  } cmd_t;

  typedef struct packed {
    logic acc_done;
  } stat_t;

endpackage

>>> sv/dmma_ctrl.sv
module dmma_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [4:0]              cfg_data,
  input  dmma_pkg::stat_t         stat,
  output dmma_pkg::cmd_t          cmd
);
  import dmma_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]       state;
  logic [4:0]       size_in_use;
  logic [IDX_W-1:0] next_row;
  logic [IDX_W-1:0] row_i;
  logic [IDX_W-1:0] col_j;
  logic [IDX_W-1:0] k_cnt;
  logic [ORD_W-1:0] order;
  logic [ORD_W-1:0] order_m1;
  logic             accept;
  logic             k_last;
  logic             col_last;
  logic [ORD_W-1:0] row_inc;

  always_comb begin
    if (size_in_use == 5'd0) begin
      order = ORD_W'(1);
    end else if (ORD_W'(size_in_use) > ORD_W'(MAX_SIZE)) begin
      order = ORD_W'(MAX_SIZE);
    end else begin
      order = ORD_W'(size_in_use);
    end
  end

  assign order_m1  = order - ORD_W'(1);
  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start && (state == S_IDLE);
  assign k_last    = ({1'b0, k_cnt} == order_m1);
  assign col_last  = ({1'b0, col_j} == order_m1);
  assign row_inc   = {1'b0, row_i} + ORD_W'(1);

  always_comb begin
    cmd           = '0;
    cmd.load      = accept && (kind != KIND_COMPUTE);
    cmd.load_kind = kind;
    cmd.issue     = (state == S_ISSUE);
    cmd.first     = (k_cnt == '0);
    cmd.last      = k_last;
    cmd.store     = (state == S_DRAIN) && stat.acc_done;
    cmd.last_col  = col_last;
    cmd.row       = row_i;
    cmd.col       = col_j;
    cmd.k         = k_cnt;
    cmd.order     = order;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      size_in_use <= 5'(MAX_SIZE);
      next_row    <= '0;
      row_i       <= '0;
      col_j       <= '0;
      k_cnt       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_in_use <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept && (kind == KIND_COMPUTE)) begin
            row_i <= ({1'b0, next_row} >= order) ? '0 : next_row;
            col_j <= '0;
            k_cnt <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (k_last) begin
            state <= S_DRAIN;
          end else begin
            k_cnt <= k_cnt + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (stat.acc_done) begin
            if (col_last) begin
              next_row <= (row_inc >= order) ? '0 : row_inc[IDX_W-1:0];
              state    <= S_IDLE;
            end else begin
              col_j <= col_j + IDX_W'(1);
              k_cnt <= '0;
              state <= S_ISSUE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/dmma_dpath.sv
module dmma_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  dmma_pkg::cmd_t                    cmd,
  input  logic signed [dmma_pkg::ELEMENT_BITS-1:0] value,
  output dmma_pkg::stat_t                   stat,
  output logic                              strobe,
  output logic [3:0]                        row,
  output logic [3:0]                        column,
  output logic signed [31:0]                result,
  output logic                              last_of_row
);
  import dmma_pkg::*;

  logic signed [ELEMENT_BITS-1:0] mem_a [CELLS];
  logic signed [ELEMENT_BITS-1:0] mem_b [CELLS];
  logic signed [ELEMENT_BITS-1:0] mem_c [CELLS];

  logic [ADDR_W-1:0] a_load_index;
  logic [ADDR_W-1:0] b_load_index;
  logic [ADDR_W-1:0] c_load_index;

  logic [ADDR_W:0]   total;
  logic [ADDR_W-1:0] load_cnt;
  logic [ADDR_W-1:0] load_at;
  logic [ADDR_W:0]   load_inc;
  logic [ADDR_W-1:0] load_cnt_next;

  logic [ADDR_W:0]   row_base;
  logic [ADDR_W:0]   k_base;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [ADDR_W-1:0] c_addr;

  logic signed [ELEMENT_BITS-1:0] rd_a;
  logic signed [ELEMENT_BITS-1:0] rd_b;
  logic signed [ELEMENT_BITS-1:0] rd_c;
  logic                           s1_valid;
  logic                           s1_first;
  logic                           s1_last;

  logic signed [PROD_W-1:0]       prod;
  logic signed [ELEMENT_BITS-1:0] s2_c;
  logic                           s2_valid;
  logic                           s2_first;
  logic                           s2_last;

  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_base;
  logic signed [ACC_W-1:0]        acc_next;
  logic                           acc_done;

  logic [ACC_W-ELEMENT_BITS-FRAC_BITS:0] acc_top;
  logic signed [ELEMENT_BITS-1:0]        sat;

  assign total = (ADDR_W+1)'(cmd.order * cmd.order);

  always_comb begin
    case (cmd.load_kind)
      KIND_LOAD_A: load_cnt = a_load_index;
      KIND_LOAD_B: load_cnt = b_load_index;
      default:     load_cnt = c_load_index;
    endcase
  end

  assign load_at       = ({1'b0, load_cnt} >= total) ? '0 : load_cnt;
  assign load_inc      = {1'b0, load_at} + (ADDR_W+1)'(1);
  assign load_cnt_next = (load_inc >= total) ? '0 : load_inc[ADDR_W-1:0];

  // row-major at stride n
  assign row_base = (ADDR_W+1)'(cmd.row * cmd.order);
  assign k_base   = (ADDR_W+1)'(cmd.k * cmd.order);
  assign a_addr   = ADDR_W'(row_base + (ADDR_W+1)'(cmd.k));
  assign b_addr   = ADDR_W'(k_base + (ADDR_W+1)'(cmd.col));
  assign c_addr   = ADDR_W'(row_base + (ADDR_W+1)'(cmd.col));

  always_ff @(posedge clk) begin
    if (cmd.load && (cmd.load_kind == KIND_LOAD_A)) begin
      mem_a[load_at] <= value;
    end
    rd_a <= mem_a[a_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (cmd.load_kind == KIND_LOAD_B)) begin
      mem_b[load_at] <= value;
    end
    rd_b <= mem_b[b_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (cmd.load_kind == KIND_LOAD_C)) begin
      mem_c[load_at] <= value;
    end else if (cmd.store) begin
      mem_c[c_addr] <= sat;
    end
    rd_c <= mem_c[c_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_load_index <= '0;
      b_load_index <= '0;
      c_load_index <= '0;
    end else if (cmd.load) begin
      case (cmd.load_kind)
        KIND_LOAD_A: a_load_index <= load_cnt_next;
        KIND_LOAD_B: b_load_index <= load_cnt_next;
        KIND_LOAD_C: c_load_index <= load_cnt_next;
        default: begin
        end
      endcase
    end
  end

  assign acc_base = s2_first
      ? {{(ACC_W-ELEMENT_BITS-FRAC_BITS){s2_c[ELEMENT_BITS-1]}}, s2_c, {FRAC_BITS{1'b0}}}
      : acc;
  assign acc_next = acc_base + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      acc_done <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.first;
    s1_last  <= cmd.last;
    prod     <= rd_a * rd_b;
    s2_c     <= rd_c;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    if (s2_valid) begin
      acc <= acc_next;
    end
  end

  assign stat.acc_done = acc_done;

  // floor shift, then clamp to the element range
  assign acc_top = acc[ACC_W-1:ELEMENT_BITS+FRAC_BITS-1];

  always_comb begin
    if ((acc_top == '0) || (acc_top == '1)) begin
      sat = acc[ELEMENT_BITS+FRAC_BITS-1:FRAC_BITS];
    end else if (acc[ACC_W-1]) begin
      sat = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.store;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      row         <= 4'(cmd.row);
      column      <= 4'(cmd.col);
      result      <= sat;
      last_of_row <= cmd.last_col;
    end
  end

endmodule

>>> sv/dense_matrix_multiply_accumulate_core.sv
// C += A * B on square matrices of order n (size_in_use, 1 to 16) held in Q16.16.
// A load (kind 0..2) writes the next element of A, B or C in row-major order;
// busy stays low, so loads may be issued every cycle. A compute (kind 3)
// updates the next row of C: one multiply-accumulate unit takes one k per cycle
// from the three element memories, and each column then passes through memory
// read, product register and accumulate before it is written back. Results
// leave one per column on a one-cycle strobe; the receiver cannot stall them
// and must take each transfer as it appears. The size register accepts a
// write whenever busy is low.
module dense_matrix_multiply_accumulate_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data,
  output logic               strobe,
  output logic [3:0]         row,
  output logic [3:0]         column,
  output logic signed [31:0] result,
  output logic               last_of_row
);
  import dmma_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dmma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  dmma_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .value       (value),
    .stat        (stat),
    .strobe      (strobe),
    .row         (row),
    .column      (column),
    .result      (result),
    .last_of_row (last_of_row)
  );

endmodule

>>> tb/dmma_row_checker.sv
`timescale 1ns / 100ps

module dmma_row_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic                                     busy,
  input  logic [1:0]                               kind,
  input  logic signed [dmma_pkg::ELEMENT_BITS-1:0] value,
  input  logic                                     cfg_valid,
  input  logic                                     cfg_ready,
  input  logic [4:0]                               cfg_data,
  input  logic                                     strobe,
  input  logic [dmma_pkg::IDX_W-1:0]               row,
  input  logic [dmma_pkg::IDX_W-1:0]               column,
  input  logic signed [dmma_pkg::ELEMENT_BITS-1:0] result,
  input  logic                                     last_of_row,
  output int                                       errors,
  output int                                       pending,
  output int                                       compared
);
  import dmma_pkg::*;

  localparam logic signed [127:0] ELEM_MAX = (128'sd1 <<< (ELEMENT_BITS - 1)) - 128'sd1;
  localparam logic signed [127:0] ELEM_MIN = -ELEM_MAX - 128'sd1;

  typedef struct packed {
    logic [IDX_W-1:0]               row;
    logic [IDX_W-1:0]               column;
    logic signed [ELEMENT_BITS-1:0] value;
    logic                           last;
  } c_elem_t;

  // indexed by load kind: A, B, C
  logic signed [ELEMENT_BITS-1:0] cells [3][CELLS];
  int unsigned                    load_ptr [3];
  int unsigned                    row_ptr;
  logic [4:0]                     size_reg;
  c_elem_t                        c_row_queue [$];

  function automatic int unsigned order_of(input logic [4:0] s);
    if (s == 5'd0) return 1;
    if (s > MAX_SIZE) return MAX_SIZE;
    return s;
  endfunction

  task automatic store_element(input logic [1:0] which, input logic signed [31:0] v);
    int unsigned total;
    int unsigned at;
    total = order_of(size_reg) * order_of(size_reg);
    at = load_ptr[which];
    if (at >= total) at = 0;
    cells[which][at] = v[ELEMENT_BITS-1:0];
    at++;
    if (at >= total) at = 0;
    load_ptr[which] = at;
  endtask

  task automatic accumulate_row();
    int unsigned       n;
    int unsigned       i;
    logic signed [127:0] acc;
    logic signed [127:0] ta;
    logic signed [127:0] tb;
    c_elem_t           e;
    n = order_of(size_reg);
    i = row_ptr;
    if (i >= n) i = 0;
    for (int unsigned j = 0; j < n; j++) begin
      acc = cells[KIND_LOAD_C][i * n + j];
      acc = acc <<< FRAC_BITS;
      for (int unsigned k = 0; k < n; k++) begin
        ta = cells[KIND_LOAD_A][i * n + k];
        tb = cells[KIND_LOAD_B][k * n + j];
        acc = acc + ta * tb;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > ELEM_MAX) acc = ELEM_MAX;
      else if (acc < ELEM_MIN) acc = ELEM_MIN;
      cells[KIND_LOAD_C][i * n + j] = acc[ELEMENT_BITS-1:0];
      e.row    = i[IDX_W-1:0];
      e.column = j[IDX_W-1:0];
      e.value  = acc[ELEMENT_BITS-1:0];
      e.last   = (j + 1 == n);
      c_row_queue.push_back(e);
    end
    i++;
    if (i >= n) i = 0;
    row_ptr = i;
  endtask

  always @(posedge clk) begin : watch
    c_elem_t e;
    if (rst) begin
      c_row_queue.delete();
      load_ptr[0] = 0;
      load_ptr[1] = 0;
      load_ptr[2] = 0;
      row_ptr     = 0;
      size_reg    = 5'd16;
      errors      = 0;
      compared    = 0;
    end else begin
      if (strobe) begin
        if (c_row_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result row %0d col %0d value %h", $time, row, column,
                   result);
        end else begin
          e = c_row_queue.pop_front();
          compared++;
          if (row !== e.row) begin
            errors++;
            $display("%0t: row expected %0d got %0d", $time, e.row, row);
          end
          if (column !== e.column) begin
            errors++;
            $display("%0t: column expected %0d got %0d", $time, e.column, column);
          end
          if (result !== e.value) begin
            errors++;
            $display("%0t: result at %0d/%0d expected %h got %h", $time, e.row, e.column,
                     e.value, result);
          end
          if (last_of_row !== e.last) begin
            errors++;
            $display("%0t: last_of_row at %0d/%0d expected %b got %b", $time, e.row,
                     e.column, e.last, last_of_row);
          end
        end
      end
      // a transfer sees the size held before this edge
      if (start && !busy) begin
        if (kind == KIND_COMPUTE) accumulate_row();
        else store_element(kind, value);
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
    end
    pending = c_row_queue.size();
  end

endmodule

>>> tb/tb_dense_matrix_multiply_accumulate_core.sv
`timescale 1ns / 100ps

module tb_dense_matrix_multiply_accumulate_core;
  import dmma_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE       = 8;

  logic               clk;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  logic [1:0]         kind        = KIND_LOAD_A;
  logic signed [31:0] value       = '0;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [4:0]         cfg_data    = '0;
  logic               strobe;
  logic [3:0]         row;
  logic [3:0]         column;
  logic signed [31:0] result;
  logic               last_of_row;

  int errors;
  int pending;
  int compared;

  int               items    = 0;
  int               computes = 0;
  int               rand_base;
  bit               quiet    = 1'b0;
  int unsigned      order_now;
  logic [MAX_SIZE:0] orders_seen = '0;
  logic [CELLS-1:0] loaded [3];

  dense_matrix_multiply_accumulate_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .value       (value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .row         (row),
    .column      (column),
    .result      (result),
    .last_of_row (last_of_row)
  );

  dmma_row_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .value       (value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .row         (row),
    .column      (column),
    .result      (result),
    .last_of_row (last_of_row),
    .errors      (errors),
    .pending     (pending),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_dense_matrix_multiply_accumulate_core: done, errors");
    $finish;
  end

  // mostly small Q16.16 values so sums stay in range, some full-range and edge values
  function automatic logic [31:0] rand_value();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 55) v = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
    else if (r < 75) v = $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
    else if (r < 92) v = $urandom;
    else begin
      case ($urandom_range(0, 4))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = 32'hFFFF_FFFF;
        3:       v = 32'h0001_0000;
        default: v = 32'h0000_0000;
      endcase
    end
    return v;
  endfunction

  task automatic send_item(input logic [1:0] k, input logic [31:0] v);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    items++;
    if (k == KIND_COMPUTE) computes++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_order(input logic [4:0] s);
    wait_drained();
    cfg_data  <= s;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    order_now = (s == 5'd0) ? 1 : (s > MAX_SIZE) ? MAX_SIZE : s;
    orders_seen[order_now] = 1'b1;
  endtask

  // a full round of n*n loads covers every cell whatever the load counter holds
  task automatic fill_stores();
    int unsigned      used;
    int unsigned      left [3];
    int unsigned      m;
    logic [CELLS-1:0] mask;
    used = order_now * order_now;
    mask = {CELLS{1'b1}} >> (CELLS - used);
    for (int q = 0; q < 3; q++) left[q] = ((loaded[q] & mask) == mask) ? 0 : used;
    while (left[0] + left[1] + left[2] != 0) begin
      m = $urandom_range(0, 2);
      if (left[m] != 0) begin
        send_item(2'(m), rand_value());
        left[m]--;
      end
    end
    for (int q = 0; q < 3; q++) loaded[q] = loaded[q] | mask;
  endtask

  initial begin
    int          r;
    int          body;
    logic [4:0]  s;
    for (int q = 0; q < 3; q++) loaded[q] = '0;
    order_now = MAX_SIZE;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // order 1 via size 0: saturation both ways, truncation toward minus infinity
    set_order(5'd0);
    send_item(KIND_LOAD_A, 32'h7FFF_FFFF);
    send_item(KIND_LOAD_B, 32'h7FFF_FFFF);
    send_item(KIND_LOAD_C, 32'h0000_0000);
    send_item(KIND_COMPUTE, 32'h0000_0000);
    send_item(KIND_LOAD_A, 32'h8000_0000);
    send_item(KIND_LOAD_B, 32'h7FFF_FFFF);
    send_item(KIND_LOAD_C, 32'h8000_0000);
    send_item(KIND_COMPUTE, 32'hFFFF_FFFF);
    send_item(KIND_LOAD_A, 32'hFFFF_FFFF);
    send_item(KIND_LOAD_B, 32'h0000_0001);
    send_item(KIND_LOAD_C, 32'h0000_0000);
    send_item(KIND_COMPUTE, 32'h8000_0000);
    send_item(KIND_LOAD_A, 32'h0001_8000);
    send_item(KIND_LOAD_B, 32'h0002_0000);
    send_item(KIND_LOAD_C, 32'h0000_8000);
    send_item(KIND_COMPUTE, 32'h7FFF_FFFF);
    for (int q = 0; q < 3; q++) loaded[q][0] = 1'b1;

    // largest order: every row and column index
    set_order(5'd16);
    fill_stores();
    repeat (MAX_SIZE) begin
      send_item(KIND_COMPUTE, $urandom);
      if ($urandom_range(0, 99) < 30) send_item(2'($urandom_range(0, 2)), rand_value());
    end
    set_order(5'd31);
    repeat (3) send_item(KIND_COMPUTE, $urandom);
    set_order(5'd1);
    send_item(KIND_COMPUTE, $urandom);

    rand_base = items;
    while (items - rand_base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) s = 5'd0;
      else if (r < 13) s = 5'($urandom_range(17, 31));
      else if (r < 18) s = 5'd16;
      else if (r < 70) s = 5'($urandom_range(1, 4));
      else s = 5'($urandom_range(5, 8));
      set_order(s);
      fill_stores();
      body = $urandom_range(8, 40);
      repeat (body) begin
        quiet = (items - rand_base >= 150) && (items - rand_base < 260);
        r = $urandom_range(0, 99);
        if (r < 5) wait_drained();
        else if (r < 35) send_item(KIND_COMPUTE, $urandom);
        else send_item(2'($urandom_range(0, 2)), rand_value());
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("covered %0d transfers, %0d row computes, %0d results compared", items,
             computes, compared);
    $display("matrix orders in use (bit per order): %b, size 0 and above 16 included",
             orders_seen[MAX_SIZE:1]);
    if (errors == 0 && pending == 0) begin
      $display("tb_dense_matrix_multiply_accumulate_core: done, clean");
    end else begin
      $display("tb_dense_matrix_multiply_accumulate_core: done, errors");
    end
    $finish;
  end

endmodule

>>> dense_matrix_multiply_accumulate_core.f
sv/dmma_pkg.sv
sv/dmma_ctrl.sv
sv/dmma_dpath.sv
sv/dense_matrix_multiply_accumulate_core.sv
tb/dmma_row_checker.sv
tb/tb_dense_matrix_multiply_accumulate_core.sv
